// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the battery ADC averaging RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk, ignored while arst_n is low.
`define BACU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define BACU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bacu_pkg.sv =====
// Package with the constants, types and sequencer states of the battery ADC averaging unit.
package bacu_pkg;

	localparam int HISTORY_DEPTH = 8;
	// The rounding step is a power of two, so the rounding reduces to an add and a mask.
	localparam int STEP_SIZE     = 4;
	localparam int ROUND_ADDON   = STEP_SIZE / 2;

	localparam int SAMPLE_W  = 12;
	localparam int OFFSET_W  = 10;
	localparam int CORR_W    = 13;
	localparam int AVG_W     = 13;
	localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
	localparam int PTR_W     = $clog2(HISTORY_DEPTH);
	localparam int CORR_MAX  = (1 << SAMPLE_W) - 1 + (1 << OFFSET_W) - 1;
	localparam int SUM_W     = $clog2(HISTORY_DEPTH * CORR_MAX + 1);
	localparam int DIV_CNT_W = $clog2(SUM_W);

	localparam int IN_DATA_W  = ((SAMPLE_W + OFFSET_W + 7) / 8) * 8;
	localparam int OUT_FLD_W  = 2 * AVG_W + FILL_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_OFF,
		ST_SUM,
		ST_DIV,
		ST_FINISH
	} bacu_state_t;

	typedef struct packed {
		logic load;
		logic add;
		logic div_step;
	} bacu_alu_ctrl_t;

endpackage

// ===== rtl/bacu_ring.sv =====
// History rings of corrected samples and stored averages, one write and one read address.
module bacu_ring (
	input  logic                          clk,
	input  logic                          corr_we,
	input  logic                          avg_we,
	input  logic [bacu_pkg::PTR_W-1:0]    wr_addr,
	input  logic [bacu_pkg::CORR_W-1:0]   corr_wdata,
	input  logic [bacu_pkg::AVG_W-1:0]    avg_wdata,
	input  logic [bacu_pkg::PTR_W-1:0]    rd_addr,
	output logic [bacu_pkg::CORR_W-1:0]   corr_rdata,
	output logic [bacu_pkg::AVG_W-1:0]    avg_rdata
);
	import bacu_pkg::*;

	logic [CORR_W-1:0] corr_q [HISTORY_DEPTH];
	logic [AVG_W-1:0]  avg_q  [HISTORY_DEPTH];

	// Entries are only read once written, as the fill count limits how far back the sum goes.
	always_ff @(posedge clk) begin
		if (corr_we) begin
			corr_q[wr_addr] <= corr_wdata;
		end
		if (avg_we) begin
			avg_q[wr_addr] <= avg_wdata;
		end
	end

	assign corr_rdata = corr_q[rd_addr];
	assign avg_rdata  = avg_q[rd_addr];

endmodule

// ===== rtl/bacu_alu.sv =====
// Shared add and restoring-divide unit with its accumulator and remainder registers.
module bacu_alu (
	input  logic                            clk,
	input  bacu_pkg::bacu_alu_ctrl_t        ctrl,
	input  logic [bacu_pkg::SUM_W-1:0]      load_val,
	input  logic [bacu_pkg::SUM_W-1:0]      addend,
	input  logic [bacu_pkg::FILL_W-1:0]     divisor,
	output logic [bacu_pkg::SUM_W-1:0]      acc,
	output logic [bacu_pkg::FILL_W-1:0]     rem,
	output logic [bacu_pkg::SUM_W-1:0]      sum
);
	import bacu_pkg::*;

	logic [SUM_W-1:0]  acc_q;
	logic [FILL_W-1:0] rem_q;
	logic [FILL_W:0]   shift_val;
	logic [SUM_W:0]    op_a;
	logic [SUM_W:0]    op_b;
	logic [SUM_W:0]    res;
	logic              cin;
	logic              q_bit;

	assign shift_val = {rem_q, acc_q[SUM_W-1]};

	// In a divide step the adder forms the trial subtraction as a + ~b + 1.
	always_comb begin
		if (ctrl.div_step) begin
			op_a = (SUM_W + 1)'(shift_val);
			op_b = ~((SUM_W + 1)'(divisor));
			cin  = 1'b1;
		end else begin
			op_a = {1'b0, acc_q};
			op_b = {1'b0, addend};
			cin  = 1'b0;
		end
		res   = op_a + op_b + (SUM_W + 1)'(cin);
		q_bit = ~res[SUM_W];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= load_val;
			rem_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= res[SUM_W-1:0];
		end else if (ctrl.div_step) begin
			acc_q <= {acc_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? res[FILL_W-1:0] : shift_val[FILL_W-1:0];
		end
	end

	assign acc = acc_q;
	assign rem = rem_q;
	assign sum = res[SUM_W-1:0];

endmodule

// ===== rtl/battery_adc_corrected_average_unit.sv =====
// Battery ADC averaging unit: takes one raw sample and offset per input word and returns one
// averaged word. The corrected sample, the two previous corrected samples and the older stored
// averages (fill - 1 history entries in all) are summed one entry per cycle by a single shared
// adder, and the sum is then divided by the fill count with a restoring divider that produces
// one quotient bit per cycle on the same adder. An input word occupies the unit until its result
// enters the output register, and s_axis_tready is low meanwhile. A finished word waits in an
// output register, so the next input word is taken while it is still unread. History is empty
// after reset; no clearing pass runs.
module battery_adc_corrected_average_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// Fields from bit 0: sample[11:0], offset[21:12], zero padding.
	input  logic [bacu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// Fields from bit 0: level[12:0], average[25:13], fill[29:26], zero padding.
	output logic [bacu_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import bacu_pkg::*;

	bacu_state_t    state_q, state_d;
	bacu_alu_ctrl_t alu_ctrl;

	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     rd_q;
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    taken_q;
	logic [DIV_CNT_W-1:0] divcnt_q;
	logic [OFFSET_W-1:0]  off_q;
	logic                 out_valid_q;
	logic [AVG_W-1:0]     out_level_q;
	logic [AVG_W-1:0]     out_avg_q;
	logic [FILL_W-1:0]    out_fill_q;

	logic                 accept;
	logic                 out_free;
	logic                 corr_we;
	logic                 avg_we;
	logic [SUM_W-1:0]     addend;
	logic [SUM_W-1:0]     acc;
	logic [FILL_W-1:0]    rem;
	logic [SUM_W-1:0]     sum;
	logic [CORR_W-1:0]    corr_rdata;
	logic [AVG_W-1:0]     avg_rdata;
	logic [AVG_W-1:0]     avg_val;
	logic [AVG_W:0]       lvl_sum;
	logic [AVG_W-1:0]     lvl_val;

	function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] pos);
		return (pos == '0) ? PTR_W'(HISTORY_DEPTH - 1) : pos - PTR_W'(1);
	endfunction

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign avg_val = acc[AVG_W-1:0];
	assign lvl_sum = (AVG_W + 1)'(avg_val) + (AVG_W + 1)'(ROUND_ADDON);
	assign lvl_val = AVG_W'((lvl_sum / STEP_SIZE) * STEP_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		alu_ctrl      = '0;
		addend        = '0;
		corr_we       = 1'b0;
		avg_we        = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					alu_ctrl.load = 1'b1;
					state_d       = ST_ADD_OFF;
				end
			end
			ST_ADD_OFF: begin
				// The corrected sample is written to history straight from the adder.
				alu_ctrl.add = 1'b1;
				addend       = SUM_W'(off_q);
				corr_we      = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				if (taken_q == fill_q - FILL_W'(1)) begin
					state_d = ST_DIV;
				end else begin
					alu_ctrl.add = 1'b1;
					// The two newest history entries count as corrected samples, older ones as averages.
					addend = (taken_q < FILL_W'(2)) ? SUM_W'(corr_rdata) : SUM_W'(avg_rdata);
				end
			end
			ST_DIV: begin
				alu_ctrl.div_step = 1'b1;
				if (divcnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					avg_we  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && (fill_q < FILL_W'(HISTORY_DEPTH))) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (avg_we) begin
				head_q      <= (head_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_q <= s_axis_tdata[SAMPLE_W +: OFFSET_W];
			rd_q  <= prev_slot(head_q);
		end
		if (state_q == ST_ADD_OFF) begin
			taken_q <= '0;
		end else if (alu_ctrl.add) begin
			taken_q <= taken_q + FILL_W'(1);
			rd_q    <= prev_slot(rd_q);
		end
		if (state_q == ST_SUM) begin
			divcnt_q <= '0;
		end else if (alu_ctrl.div_step) begin
			divcnt_q <= divcnt_q + DIV_CNT_W'(1);
		end
		if (avg_we) begin
			out_level_q <= lvl_val;
			out_avg_q   <= avg_val;
			out_fill_q  <= fill_q;
		end
	end

	bacu_alu u_alu (
		.clk      (clk),
		.ctrl     (alu_ctrl),
		.load_val (SUM_W'(s_axis_tdata[SAMPLE_W-1:0])),
		.addend   (addend),
		.divisor  (fill_q),
		.acc      (acc),
		.rem      (rem),
		.sum      (sum)
	);

	bacu_ring u_ring (
		.clk        (clk),
		.corr_we    (corr_we),
		.avg_we     (avg_we),
		.wr_addr    (head_q),
		.corr_wdata (sum[CORR_W-1:0]),
		.avg_wdata  (avg_val),
		.rd_addr    (rd_q),
		.corr_rdata (corr_rdata),
		.avg_rdata  (avg_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_fill_q, out_avg_q, out_level_q};

	`include "assert_macros.svh"

	`BACU_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_ADD_OFF, "accepted word did not start the sequence")
	`BACU_ASSERT(a_rem_below_fill, (state_q != ST_FINISH) || (rem < fill_q), "division remainder not below fill count")
	`BACU_ASSERT(a_out_fill_range, !out_valid_q || ((out_fill_q != '0) && (out_fill_q <= FILL_W'(HISTORY_DEPTH))), "result fill count out of range")
	`BACU_ASSERT(a_level_near_avg, !out_valid_q || (((AVG_W + 1)'(out_level_q) + (AVG_W + 1)'(ROUND_ADDON) >= (AVG_W + 1)'(out_avg_q)) && ((AVG_W + 1)'(out_level_q) <= (AVG_W + 1)'(out_avg_q) + (AVG_W + 1)'(ROUND_ADDON))), "level too far from average")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the battery ADC corrected averaging unit.
module tb_top;
	import bacu_pkg::*;

	localparam int RANDOM_WORDS = 1330;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIR_ROWS     = 20;

	typedef struct packed {
		logic [AVG_W-1:0]  level;
		logic [AVG_W-1:0]  average;
		logic [FILL_W-1:0] fill;
	} reading_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [OFFSET_W-1:0] offset;
		bit                  typed;
		reading_t            want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Predictor copy of the history rings, write pointer and fill count.
	logic [SAMPLE_W-1:0] sample_hist [HISTORY_DEPTH] = '{default: '0};
	logic [OFFSET_W-1:0] offset_hist [HISTORY_DEPTH] = '{default: '0};
	logic [AVG_W-1:0]    avg_hist    [HISTORY_DEPTH] = '{default: '0};
	logic [PTR_W-1:0]    wr_ptr   = '0;
	int unsigned         fill_cnt = 0;

	reading_t pending_readings [$];
	int       words_sent     = 0;
	int       words_checked  = 0;
	int       mismatch_count = 0;
	bit       hold_request   = 1'b0;
	int       holds_done     = 0;

	// Directed words: extremes, walking bit patterns, saturation of the fill count and
	// wrap of the write pointer. The opening rows can be worked out by hand.
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{12'hFFF, 10'h3FF, 1'b1, '{13'd5120, 13'd5118, 4'd1}},
		'{12'h000, 10'h000, 1'b1, '{13'd2560, 13'd2559, 4'd2}},
		'{12'h000, 10'h000, 1'b1, '{13'd1708, 13'd1706, 4'd3}},
		'{12'hFFF, 10'h000, 1'b0, '0},
		'{12'h000, 10'h3FF, 1'b0, '0},
		'{12'hAAA, 10'h155, 1'b0, '0},
		'{12'h555, 10'h2AA, 1'b0, '0},
		'{12'h800, 10'h200, 1'b0, '0},
		'{12'h001, 10'h001, 1'b0, '0},
		'{12'h7FF, 10'h1FF, 1'b0, '0},
		'{12'hFFF, 10'h3FF, 1'b0, '0},
		'{12'hFFF, 10'h3FF, 1'b0, '0},
		'{12'hFFF, 10'h3FF, 1'b0, '0},
		'{12'h000, 10'h000, 1'b0, '0},
		'{12'h002, 10'h000, 1'b0, '0},
		'{12'h001, 10'h001, 1'b0, '0},
		'{12'h003, 10'h000, 1'b0, '0},
		'{12'h000, 10'h001, 1'b0, '0},
		'{12'hF0F, 10'h0F0, 1'b0, '0},
		'{12'h0F0, 10'h30F, 1'b0, '0}
	};

	battery_adc_corrected_average_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advances the history by one word and returns the smoothed reading it produces.
	function automatic reading_t smooth_next(input logic [SAMPLE_W-1:0] smp,
			input logic [OFFSET_W-1:0] off);
		int unsigned      total;
		logic [PTR_W-1:0] pos;
		int unsigned      avg;
		int unsigned      lvl;
		reading_t         r;
		if (fill_cnt < HISTORY_DEPTH) begin
			fill_cnt++;
		end
		sample_hist[wr_ptr] = smp;
		offset_hist[wr_ptr] = off;
		total = 32'(smp) + 32'(off);
		pos = wr_ptr;
		// The two newest older entries count as corrected samples, the rest as stored averages.
		for (int n = 0; n + 1 < fill_cnt; n++) begin
			pos = (pos == '0) ? PTR_W'(HISTORY_DEPTH - 1) : pos - PTR_W'(1);
			if (n < 2) begin
				total += 32'(sample_hist[pos]) + 32'(offset_hist[pos]);
			end else begin
				total += 32'(avg_hist[pos]);
			end
		end
		avg = total / fill_cnt;
		avg_hist[wr_ptr] = AVG_W'(avg);
		lvl = ((avg + ROUND_ADDON) / STEP_SIZE) * STEP_SIZE;
		wr_ptr = (wr_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
		r.level   = AVG_W'(lvl);
		r.average = AVG_W'(avg);
		r.fill    = FILL_W'(fill_cnt);
		return r;
	endfunction

	task automatic offer_word(input logic [SAMPLE_W-1:0] smp, input logic [OFFSET_W-1:0] off,
			input bit typed, input reading_t typed_r);
		reading_t predicted;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - SAMPLE_W - OFFSET_W){1'b0}}, off, smp};
		do @(posedge clk); while (!s_axis_tready);
		predicted = smooth_next(smp, off);
		pending_readings.push_back(typed ? typed_r : predicted);
		words_sent++;
	endtask

	// Ends the current burst now and then with an idle gap of random length.
	task automatic burst_gap(inout int burst_left);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	initial begin
		int                  burst_left;
		int                  kind;
		logic [SAMPLE_W-1:0] smp;
		logic [OFFSET_W-1:0] off;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		burst_left    = 0;
		smp           = '0;
		off           = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i >= 8) begin
				burst_gap(burst_left);
			end
			offer_word(directed_rows[i].sample, directed_rows[i].offset,
				directed_rows[i].typed, directed_rows[i].want);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 300) begin
				hold_request = 1'b1;
			end
			if (i == 800) begin
				// Let the unit run dry before carrying on.
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (pending_readings.size() != 0) @(posedge clk);
			end else begin
				burst_gap(burst_left);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					smp = $urandom_range(0, 1) ? '1 : '0;
					off = $urandom_range(0, 1) ? '1 : '0;
				end
				1: begin
					smp = SAMPLE_W'($urandom_range(0, 7));
					off = OFFSET_W'($urandom_range(0, 3));
				end
				2, 3: begin
					// Repeat the previous word so that the averages settle.
				end
				default: begin
					smp = SAMPLE_W'($urandom_range(0, 4095));
					off = OFFSET_W'($urandom_range(0, 1023));
				end
			endcase
			offer_word(smp, off, 1'b0, '0);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run sent %0d words (%0d directed) and checked %0d results;", words_sent,
			DIR_ROWS, words_checked);
		$display("it included %0d long output stall(s), a full drain pause and %0d mismatches.",
			holds_done, mismatch_count);
		if (mismatch_count == 0 && pending_readings.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Output side stalls on its own randomly chosen pattern, which changes periodically.
	initial begin
		int mode;
		int phase_cnt;
		m_axis_tready = 1'b0;
		mode          = 0;
		phase_cnt     = 0;
		forever begin
			@(negedge clk);
			if (hold_request && holds_done == 0) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
				m_axis_tready <= 1'b1;
			end else begin
				if (phase_cnt % 50 == 0) begin
					mode = $urandom_range(0, 3);
				end
				phase_cnt++;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default: m_axis_tready <= (phase_cnt % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_output
		reading_t got_r;
		reading_t want_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_r.level   = m_axis_tdata[AVG_W-1:0];
			got_r.average = m_axis_tdata[2*AVG_W-1:AVG_W];
			got_r.fill    = m_axis_tdata[2*AVG_W+FILL_W-1:2*AVG_W];
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result word: level %0d average %0d fill %0d",
						got_r.level, got_r.average, got_r.fill);
				end
			end else begin
				want_r = pending_readings.pop_front();
				if (got_r.level !== want_r.level || got_r.average !== want_r.average ||
						got_r.fill !== want_r.fill) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d wrong: want level %0d average %0d fill %0d, got level %0d average %0d fill %0d",
							words_checked, want_r.level, want_r.average, want_r.fill,
							got_r.level, got_r.average, got_r.fill);
					end
				end
				words_checked++;
			end
		end
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bacu_pkg.sv
rtl/bacu_ring.sv
rtl/bacu_alu.sv
rtl/battery_adc_corrected_average_unit.sv
tb/sv/tb_top.sv
